/* hdl/slgt_pkg.sv */
package slgt_pkg;

    // Default fraction width of the linear-light values
    localparam int LINEAR_FRACTION_BITS_DEF = 16;

    // Threshold register
    localparam int                    THRESHOLD_W     = 9;
    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 9'd80;

    // Stream payload widths
    localparam int CODE_W     = 8;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 16;
    localparam int SEARCH_STG = 8;

    // Rec.709 luminance weights, Q0.16, summing to 1.0
    localparam int          WEIGHT_W     = 16;
    localparam logic [15:0] WEIGHT_RED   = 16'd13933;
    localparam logic [15:0] WEIGHT_GREEN = 16'd46871;
    localparam logic [15:0] WEIGHT_BLUE  = 16'd4732;
    localparam logic [16:0] ROUND_HALF   = 17'd32768;

    // Scratch width for the exact power evaluation during elaboration
    typedef logic [511:0] t_wide;

    // floor(2^fb * (n/d)^(12/5)) in [31:0], bit 32 set when no fraction remains.
    // Bisection on x^5 * d^12 <= n^12 * 2^(5*fb).
    function automatic logic [32:0] pow_floor(input logic [31:0] n, input logic [31:0] d,
                                              input int unsigned fb);
        t_wide       rhs;
        t_wide       lhs;
        t_wide       d12;
        t_wide       m5;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] mid;
        int          i;
        int          it;
        rhs = t_wide'(1);
        d12 = t_wide'(1);
        for (i = 0; i < 12; i++) begin
            rhs = rhs * t_wide'(n);
            d12 = d12 * t_wide'(d);
        end
        rhs = rhs << (5 * fb);
        lo  = 32'd0;
        hi  = (32'd1 << fb) + 32'd1;
        for (it = 0; it < 40; it++) begin
            if (hi - lo > 32'd1) begin
                mid = lo + ((hi - lo) >> 1);
                m5  = t_wide'(1);
                for (i = 0; i < 5; i++) m5 = m5 * t_wide'(mid);
                lhs = m5 * d12;
                if (lhs <= rhs) lo = mid;
                else            hi = mid;
            end
        end
        m5 = t_wide'(1);
        for (i = 0; i < 5; i++) m5 = m5 * t_wide'(lo);
        lhs = m5 * d12;
        return {(lhs == rhs), lo};
    endfunction

    // Linear-light value of an sRGB code, Q0.fb, rounded to nearest (tie up)
    function automatic logic [31:0] lin_entry(input int unsigned code, input int unsigned fb);
        logic [63:0] num;
        logic [32:0] pf;
        if (64'(code) * 64'd100000 < 64'd1031475) begin
            // toe segment: code / 255 / 12.92
            num = (64'(code) * 64'd100) << fb;
            return 32'((64'd2 * num + 64'd329460) / 64'd658920);
        end
        pf = pow_floor(32'(code) * 32'd1000 + 32'd14025, 32'd269025, fb + 1);
        return (pf[31:0] + 32'd1) >> 1;
    endfunction

    // Breakpoint: smallest Q0.fb value at or above the linear value of
    // code midpoint (idx + 0.5) / 255
    function automatic logic [31:0] bp_entry(input int unsigned idx, input int unsigned fb);
        logic [63:0] odd;
        logic [63:0] num;
        logic [32:0] pf;
        odd = 64'd2 * 64'(idx) + 64'd1;
        if (odd * 64'd1000000000 <= 64'd20629467360) begin
            num = (odd * 64'd100) << fb;
            return 32'((num + 64'd658919) / 64'd658920);
        end
        pf = pow_floor(32'(odd) * 32'd1000 + 32'd28050, 32'd538050, fb);
        return pf[31:0] + {31'd0, ~pf[32]};
    endfunction

endpackage

/* hdl/srgb_luma_gray_threshold.sv */
// sRGB pixel to gamma-correct gray code plus a white/black class bit.
// One pixel per clock beat in and out while m_axis_tready is high, through
// 3 stages (channel linearization lookup, Rec.709 weight multiply, sum and
// round) and then 8 stages of a binary search over the 255 code-midpoint
// breakpoints, one gray bit per stage, the last also comparing against the
// threshold. Every stage keeps its beat under backpressure and fills bubbles,
// so s_axis_tready follows m_axis_tready. The threshold register (reset 80)
// is written through the cfg channel, which is always ready; write it only
// while no pixel is in flight. Thresholds above 255 give is_white of 0.
module srgb_luma_gray_threshold #(
    parameter int LINEAR_FRACTION_BITS = slgt_pkg::LINEAR_FRACTION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // pixel in
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [slgt_pkg::S_DATA_W-1:0]       s_axis_tdata,   // red, green, blue
    // result out
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [slgt_pkg::M_DATA_W-1:0]       m_axis_tdata,   // gray, is_white, zero pad
    // threshold write
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [slgt_pkg::THRESHOLD_W-1:0]    i_cfg_data
);
    import slgt_pkg::*;

    logic [THRESHOLD_W-1:0]        r_threshold;
    logic                          w_mid_valid;
    logic                          w_mid_ready;
    logic [LINEAR_FRACTION_BITS:0] w_luma;
    logic [CODE_W-1:0]             w_gray;
    logic                          w_white;

    // threshold register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_valid) begin
            r_threshold <= i_cfg_data;
        end
    end

    // linearize and weight
    slgt_luma #(
        .LINEAR_FRACTION_BITS (LINEAR_FRACTION_BITS)
    ) u_luma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_red   (s_axis_tdata[7:0]),
        .i_green (s_axis_tdata[15:8]),
        .i_blue  (s_axis_tdata[23:16]),
        .o_valid (w_mid_valid),
        .i_ready (w_mid_ready),
        .o_luma  (w_luma)
    );

    // encode back to sRGB code and classify
    slgt_encode #(
        .LINEAR_FRACTION_BITS (LINEAR_FRACTION_BITS)
    ) u_encode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_mid_valid),
        .o_ready     (w_mid_ready),
        .i_luma      (w_luma),
        .i_threshold (r_threshold),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_gray      (w_gray),
        .o_white     (w_white)
    );

    assign m_axis_tdata = {(M_DATA_W - CODE_W - 1)'(0), w_white, w_gray};

    // a draining output never blocks the input side
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

    a_cfg_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> (r_threshold == $past(i_cfg_data)))
        else $error("threshold write lost");

endmodule

/* hdl/slgt_luma.sv */
module slgt_luma #(
    parameter int LINEAR_FRACTION_BITS = slgt_pkg::LINEAR_FRACTION_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [slgt_pkg::CODE_W-1:0]     i_red,
    input  logic [slgt_pkg::CODE_W-1:0]     i_green,
    input  logic [slgt_pkg::CODE_W-1:0]     i_blue,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [LINEAR_FRACTION_BITS:0]   o_luma
);
    import slgt_pkg::*;

    localparam int LW     = LINEAR_FRACTION_BITS + 1;
    localparam int PW     = LW + WEIGHT_W;
    localparam int SW     = PW + 2;
    localparam int NSTG   = 3;
    localparam logic [LW-1:0] Y_MAX = LW'(1) << LINEAR_FRACTION_BITS;

    // sRGB code to linear light, constant table
    logic [LW-1:0] w_lin_tab [256];
    for (genvar c = 0; c < 256; c++) begin : g_lin
        localparam logic [31:0] ENTRY = lin_entry(c, LINEAR_FRACTION_BITS);
        assign w_lin_tab[c] = ENTRY[LW-1:0];
    end

    logic [NSTG-1:0] r_vld;
    logic [NSTG:0]   w_rdy;
    logic [LW-1:0]   r_lin  [3];
    logic [PW-1:0]   r_prod [3];
    logic [LW-1:0]   r_y;
    logic [SW-1:0]   n_sum;

    // stage ready chain: a stage loads when empty or when its beat moves on
    assign w_rdy[NSTG] = i_ready;
    for (genvar s = 0; s < NSTG; s++) begin : g_rdy
        assign w_rdy[s] = !r_vld[s] || w_rdy[s+1];
    end
    assign o_ready = w_rdy[0];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) r_vld[0] <= i_valid;
            if (w_rdy[1]) r_vld[1] <= r_vld[0];
            if (w_rdy[2]) r_vld[2] <= r_vld[1];
        end
    end

    // stage 0: table lookups
    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_lin[0] <= w_lin_tab[i_red];
            r_lin[1] <= w_lin_tab[i_green];
            r_lin[2] <= w_lin_tab[i_blue];
        end
    end

    // stage 1: weight products
    always_ff @(posedge i_clk) begin
        if (w_rdy[1] && r_vld[0]) begin
            r_prod[0] <= PW'(r_lin[0]) * PW'(WEIGHT_RED);
            r_prod[1] <= PW'(r_lin[1]) * PW'(WEIGHT_GREEN);
            r_prod[2] <= PW'(r_lin[2]) * PW'(WEIGHT_BLUE);
        end
    end

    // stage 2: sum, round half up, drop the weight fraction
    always_comb begin
        n_sum = SW'(r_prod[0]) + SW'(r_prod[1]) + SW'(r_prod[2]) + SW'(ROUND_HALF);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[2] && r_vld[1]) begin
            r_y <= n_sum[LW+WEIGHT_W-1:WEIGHT_W];
        end
    end

    assign o_valid = r_vld[2];
    assign o_luma  = r_y;

    // weights sum to one, so luminance never passes full scale
    a_luma_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r_y <= Y_MAX))
        else $error("luminance above full scale");

endmodule

/* hdl/slgt_encode.sv */
module slgt_encode #(
    parameter int LINEAR_FRACTION_BITS = slgt_pkg::LINEAR_FRACTION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [LINEAR_FRACTION_BITS:0]       i_luma,
    input  logic [slgt_pkg::THRESHOLD_W-1:0]    i_threshold,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [slgt_pkg::CODE_W-1:0]         o_gray,
    output logic                                o_white
);
    import slgt_pkg::*;

    localparam int LW   = LINEAR_FRACTION_BITS + 1;
    localparam int NSTG = SEARCH_STG;

    // breakpoint table; the last slot is never addressed
    logic [LW-1:0] w_bp_tab [256];
    for (genvar k = 0; k < 256; k++) begin : g_bp
        if (k < 255) begin : g_used
            localparam logic [31:0] ENTRY = bp_entry(k, LINEAR_FRACTION_BITS);
            assign w_bp_tab[k] = ENTRY[LW-1:0];
        end else begin : g_pad
            assign w_bp_tab[k] = '1;
        end
    end

    logic [NSTG-1:0]   r_vld;
    logic [NSTG:0]     w_rdy;
    logic [LW-1:0]     r_y    [NSTG-1];
    logic [CODE_W-1:0] r_g    [NSTG];
    logic              r_white;
    logic              w_v_in [NSTG];
    logic [LW-1:0]     w_y_in [NSTG];
    logic [CODE_W-1:0] w_g_in [NSTG];
    logic [CODE_W-1:0] w_cand [NSTG];
    logic [CODE_W-1:0] w_idx  [NSTG];
    logic [CODE_W-1:0] n_g    [NSTG];

    assign w_rdy[NSTG] = i_ready;
    assign o_ready     = w_rdy[0];

    // one code bit per stage, MSB first: keep the bit when its breakpoint is reached
    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        localparam logic [CODE_W-1:0] BIT = CODE_W'(1) << (NSTG - 1 - s);

        if (s == 0) begin : g_first
            assign w_v_in[s] = i_valid;
            assign w_y_in[s] = i_luma;
            assign w_g_in[s] = '0;
        end else begin : g_next
            assign w_v_in[s] = r_vld[s-1];
            assign w_y_in[s] = r_y[s-1];
            assign w_g_in[s] = r_g[s-1];
        end

        assign w_rdy[s] = !r_vld[s] || w_rdy[s+1];

        always_comb begin
            w_cand[s] = w_g_in[s] | BIT;
            w_idx[s]  = w_cand[s] - CODE_W'(1);
            n_g[s]    = (w_bp_tab[w_idx[s]] <= w_y_in[s]) ? w_cand[s] : w_g_in[s];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (w_rdy[s]) begin
                r_vld[s] <= w_v_in[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[s] && w_v_in[s]) begin
                r_g[s] <= n_g[s];
            end
        end

        if (s < NSTG - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (w_rdy[s] && w_v_in[s]) begin
                    r_y[s] <= w_y_in[s];
                end
            end
        end
    end

    // threshold compare on the final code
    always_ff @(posedge i_clk) begin
        if (w_rdy[NSTG-1] && w_v_in[NSTG-1]) begin
            r_white <= ({1'b0, n_g[NSTG-1]} >= i_threshold);
        end
    end

    assign o_valid = r_vld[NSTG-1];
    assign o_gray  = r_g[NSTG-1];
    assign o_white = r_white;

    // bits not yet decided halfway down the search are still clear
    a_search_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> (r_g[3][3:0] == 4'd0))
        else $error("undecided code bits set mid-search");

endmodule
